[rtl/mecanum_wheel_mix_encode_core_defines.svh]
// ----------------------------------------------------------------------------
// mecanum wheel mixer assertion macros
// shared concurrent assertion forms, clocked on clk_i and off during reset
// ----------------------------------------------------------------------------
`ifndef MECANUM_WHEEL_MIX_ENCODE_CORE_DEFINES_SVH
`define MECANUM_WHEEL_MIX_ENCODE_CORE_DEFINES_SVH

// plain property, checked every cycle out of reset
`define MWME_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define MWME_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/mwme_pkg.sv]
// ----------------------------------------------------------------------------
// mecanum wheel mixer package
// widths, register codes and pipeline payload types
// ----------------------------------------------------------------------------
package mwme_pkg;

  localparam int unsigned FracBits  = 8;
  localparam int unsigned VelW      = 24;
  localparam int unsigned SumW      = VelW + 2;
  // three inputs of VelW bits sum to at most 3 * 2^(VelW-1) in magnitude
  localparam int unsigned MagW      = SumW - 1;
  localparam int unsigned RpmW      = 15;
  localparam int unsigned ProdW     = MagW + RpmW;
  localparam int unsigned NumW      = ProdW + 1;
  localparam int unsigned DenW      = MagW + 4;
  localparam int unsigned QuoW      = RpmW;
  localparam int unsigned WheelW    = 16;
  localparam int unsigned NumWheels = 4;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [DenW-1:0]     Half          = DenW'(1) << (FracBits - 1);
  localparam logic [RpmW-1:0]     MaxRpmReset   = RpmW'(5000);
  localparam logic                FineModeReset = 1'b1;
  localparam logic [CfgIdxW-1:0]  RegMaxRpm     = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0]  RegFineMode   = CfgIdxW'(1);
  localparam logic [WheelW-1:0]   WheelMinCode  = {1'b1, {(WheelW-1){1'b0}}};

  typedef logic [MagW-1:0]            mag_t;
  typedef logic [RpmW-1:0]            rpm_t;
  typedef logic [QuoW-1:0]            quo_t;
  typedef logic [DenW-1:0]            den_t;
  typedef logic signed [SumW-1:0]     sum_t;
  typedef logic signed [WheelW-1:0]   wheel_t;

  typedef struct packed {
    logic [NumWheels-1:0]   neg;
    mag_t [NumWheels-1:0]   mag;
    mag_t                   amax;
  } mix_t;

  typedef struct packed {
    den_t rem;
    quo_t quo;
  } lane_t;

  typedef struct packed {
    logic                   scaled;
    logic [NumWheels-1:0]   neg;
    quo_t [NumWheels-1:0]   direct;
  } side_t;

  typedef struct packed {
    side_t                  side;
    den_t                   den;
    lane_t [NumWheels-1:0]  lane;
  } div_t;

endpackage

[rtl/mwme_if.sv]
// ----------------------------------------------------------------------------
// mecanum wheel mixer channels
// command, wheel speed and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface mwme_cmd_if;
  import mwme_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [VelW-1:0] vel_y;
  logic signed [VelW-1:0] vel_x;
  logic signed [VelW-1:0] vel_w;
  modport source (output valid, output vel_y, output vel_x, output vel_w, input ready);
  modport sink   (input valid, input vel_y, input vel_x, input vel_w, output ready);
endinterface

interface mwme_whl_if;
  import mwme_pkg::*;
  logic   valid;
  logic   ready;
  wheel_t wheel_a_x10;
  wheel_t wheel_b_x10;
  wheel_t wheel_c_x10;
  wheel_t wheel_d_x10;
  modport source (output valid, output wheel_a_x10, output wheel_b_x10,
                  output wheel_c_x10, output wheel_d_x10, input ready);
  modport sink   (input valid, input wheel_a_x10, input wheel_b_x10,
                  input wheel_c_x10, input wheel_d_x10, output ready);
endinterface

interface mwme_cfg_if;
  import mwme_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/mwme_mix.sv]
// ----------------------------------------------------------------------------
// mecanum wheel mixer front end
// mixes the command into four wheel sums, takes magnitudes and their maximum
// ----------------------------------------------------------------------------
module mwme_mix (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [mwme_pkg::VelW-1:0] vel_y_i,
  input  logic signed [mwme_pkg::VelW-1:0] vel_x_i,
  input  logic signed [mwme_pkg::VelW-1:0] vel_w_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mwme_pkg::mix_t                mix_o
);
  import mwme_pkg::*;

  logic [2:0] valid_q;
  logic [2:0] valid_d;
  logic [2:0] ld;

  sum_t                 sum_d [NumWheels];
  sum_t                 sum_q [NumWheels];
  logic [NumWheels-1:0] neg_d;
  logic [NumWheels-1:0] neg_q;
  mag_t                 mag_d [NumWheels];
  mag_t                 mag_q [NumWheels];
  mix_t                 mix_d;
  mix_t                 mix_q;

  always_comb begin
    ld[2] = !valid_q[2] || out_ready_i;
    ld[1] = !valid_q[1] || ld[2];
    ld[0] = !valid_q[0] || ld[1];
    valid_d[0] = ld[0] ? in_valid_i : valid_q[0];
    valid_d[1] = ld[1] ? valid_q[0] : valid_q[1];
    valid_d[2] = ld[2] ? valid_q[1] : valid_q[2];
  end

  // wheel sums
  always_comb begin
    sum_t ye;
    sum_t xe;
    sum_t we;
    ye = SumW'(vel_y_i);
    xe = SumW'(vel_x_i);
    we = SumW'(vel_w_i);
    sum_d[0] = we + ye - xe;
    sum_d[1] = we + ye + xe;
    sum_d[2] = we - ye + xe;
    sum_d[3] = we - ye - xe;
  end

  // magnitudes
  always_comb begin
    logic [SumW-1:0] abs_v;
    for (int i = 0; i < NumWheels; i++) begin
      abs_v    = sum_q[i][SumW-1] ? SumW'(-sum_q[i]) : SumW'(sum_q[i]);
      neg_d[i] = sum_q[i][SumW-1];
      mag_d[i] = abs_v[MagW-1:0];
    end
  end

  // largest magnitude
  always_comb begin
    mag_t m01;
    mag_t m23;
    m01 = (mag_q[0] > mag_q[1]) ? mag_q[0] : mag_q[1];
    m23 = (mag_q[2] > mag_q[3]) ? mag_q[2] : mag_q[3];
    mix_d.neg  = neg_q;
    for (int i = 0; i < NumWheels; i++) begin
      mix_d.mag[i] = mag_q[i];
    end
    mix_d.amax = (m01 > m23) ? m01 : m23;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      sum_q <= sum_d;
    end
    if (ld[1]) begin
      neg_q <= neg_d;
      mag_q <= mag_d;
    end
    if (ld[2]) begin
      mix_q <= mix_d;
    end
  end

  assign in_ready_o  = ld[0];
  assign out_valid_o = valid_q[2];
  assign mix_o       = mix_q;

endmodule

[rtl/mwme_scale.sv]
// ----------------------------------------------------------------------------
// mecanum wheel mixer scaling setup
// limit products, direct encodings and divider operands for each wheel
// ----------------------------------------------------------------------------
module mwme_scale (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mwme_pkg::rpm_t max_rpm_i,
  input  logic           fine_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mwme_pkg::mix_t mix_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mwme_pkg::div_t div_o
);
  import mwme_pkg::*;

  typedef struct packed {
    side_t                          side;
    mag_t                           amax;
    logic [NumWheels-1:0][ProdW-1:0] prod;
  } scl_t;

  logic [1:0] valid_q;
  logic [1:0] valid_d;
  logic [1:0] ld;
  scl_t       scl_d;
  scl_t       scl_q;
  div_t       div_d;
  div_t       div_q;

  always_comb begin
    ld[1] = !valid_q[1] || out_ready_i;
    ld[0] = !valid_q[0] || ld[1];
    valid_d[0] = ld[0] ? in_valid_i : valid_q[0];
    valid_d[1] = ld[1] ? valid_q[0] : valid_q[1];
  end

  // limit test, products and unscaled encodings
  always_comb begin
    den_t ten_a;
    den_t lim;
    den_t fine_v;
    mag_t whole;
    mag_t coarse_v;
    ten_a = (DenW'(mix_i.amax) << 3) + (DenW'(mix_i.amax) << 1);
    lim   = DenW'({max_rpm_i, {FracBits{1'b0}}});
    scl_d.side.scaled = ten_a > lim;
    scl_d.side.neg    = mix_i.neg;
    scl_d.amax        = mix_i.amax;
    for (int i = 0; i < NumWheels; i++) begin
      scl_d.prod[i] = ProdW'(mix_i.mag[i]) * ProdW'(max_rpm_i);
      fine_v   = ((DenW'(mix_i.mag[i]) << 3) + (DenW'(mix_i.mag[i]) << 1) + Half) >> FracBits;
      whole    = mix_i.mag[i] >> FracBits;
      coarse_v = (whole << 3) + (whole << 1);
      scl_d.side.direct[i] = fine_i ? fine_v[QuoW-1:0] : coarse_v[QuoW-1:0];
    end
  end

  // divider operands
  always_comb begin
    logic [NumW-1:0] num;
    den_t            ten_a;
    ten_a = (DenW'(scl_q.amax) << 3) + (DenW'(scl_q.amax) << 1);
    div_d.side = scl_q.side;
    div_d.den  = fine_i ? (DenW'(scl_q.amax) << 1) : ten_a;
    for (int i = 0; i < NumWheels; i++) begin
      num = fine_i ? ((NumW'(scl_q.prod[i]) << 1) + NumW'(scl_q.amax))
                   : NumW'(scl_q.prod[i]);
      div_d.lane[i].rem = DenW'(num[NumW-1:QuoW]);
      div_d.lane[i].quo = num[QuoW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      scl_q <= scl_d;
    end
    if (ld[1]) begin
      div_q <= div_d;
    end
  end

  assign in_ready_o  = ld[0];
  assign out_valid_o = valid_q[1];
  assign div_o       = div_q;

endmodule

[rtl/mwme_divider.sv]
// ----------------------------------------------------------------------------
// mecanum wheel mixer divider
// four-lane restoring divider, one quotient bit per pipeline stage
// ----------------------------------------------------------------------------
`include "mecanum_wheel_mix_encode_core_defines.svh"

module mwme_divider (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mwme_pkg::div_t div_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mwme_pkg::div_t div_o
);
  import mwme_pkg::*;

  localparam int unsigned Last = QuoW - 1;

  logic [QuoW-1:0] valid_q;
  logic            en;
  div_t            stage_d [QuoW];
  div_t            stage_q [QuoW];

  // shift in one numerator bit, subtract if it fits, shift in the quotient bit
  function automatic lane_t div_step(lane_t l, den_t den);
    logic [DenW:0] trial;
    logic [DenW:0] diff;
    logic          fits;
    lane_t         r;
    trial = {l.rem, l.quo[QuoW-1]};
    diff  = trial - {1'b0, den};
    fits  = trial >= {1'b0, den};
    r.rem = fits ? diff[DenW-1:0] : trial[DenW-1:0];
    r.quo = {l.quo[QuoW-2:0], fits};
    return r;
  endfunction

  assign en = !valid_q[Last] || out_ready_i;

  always_comb begin
    div_t src;
    for (int k = 0; k < QuoW; k++) begin
      src = (k == 0) ? div_i : stage_q[(k == 0) ? 0 : k - 1];
      stage_d[k] = src;
      for (int i = 0; i < NumWheels; i++) begin
        stage_d[k].lane[i] = div_step(src.lane[i], src.den);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[QuoW-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      stage_q <= stage_d;
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = valid_q[Last];
  assign div_o       = stage_q[Last];

  `MWME_ASSERT_IMP(a_rem_below_den, valid_q[Last] && (stage_q[Last].den != '0), (stage_q[Last].lane[0].rem < stage_q[Last].den) && (stage_q[Last].lane[1].rem < stage_q[Last].den) && (stage_q[Last].lane[2].rem < stage_q[Last].den) && (stage_q[Last].lane[3].rem < stage_q[Last].den), "divider remainder not below divisor")

endmodule

[rtl/mwme_encode.sv]
// ----------------------------------------------------------------------------
// mecanum wheel mixer encoder
// picks scaled or direct speed, clamps to the limit and applies the sign
// ----------------------------------------------------------------------------
module mwme_encode (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  mwme_pkg::rpm_t                              max_rpm_i,
  input  logic                                        fine_i,
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  mwme_pkg::div_t                              div_i,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output logic [mwme_pkg::NumWheels-1:0][mwme_pkg::WheelW-1:0] wheel_o
);
  import mwme_pkg::*;

  logic                                 valid_q;
  logic                                 ld;
  logic [NumWheels-1:0][WheelW-1:0]     wheel_d;
  logic [NumWheels-1:0][WheelW-1:0]     wheel_q;

  assign ld = !valid_q || out_ready_i;

  always_comb begin
    logic [QuoW+3:0]   q_ext;
    logic [QuoW+3:0]   q10;
    logic [QuoW+3:0]   sel;
    logic [QuoW+3:0]   lim;
    logic [WheelW-1:0] mag;
    lim = (QuoW+4)'(max_rpm_i);
    for (int i = 0; i < NumWheels; i++) begin
      q_ext = (QuoW+4)'(div_i.lane[i].quo);
      q10   = (q_ext << 3) + (q_ext << 1);
      if (div_i.side.scaled) begin
        sel = fine_i ? q_ext : q10;
      end else begin
        sel = (QuoW+4)'(div_i.side.direct[i]);
      end
      if (sel > lim) begin
        sel = lim;
      end
      mag        = WheelW'(sel[QuoW-1:0]);
      wheel_d[i] = div_i.side.neg[i] ? WheelW'(-mag) : mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ld) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      wheel_q <= wheel_d;
    end
  end

  assign in_ready_o  = ld;
  assign out_valid_o = valid_q;
  assign wheel_o     = wheel_q;

endmodule

[rtl/mecanum_wheel_mix_encode_core.sv]
// ----------------------------------------------------------------------------
// mecanum wheel mixer and rpm encoder
// cmd_i takes one chassis request (vel_y, vel_x, vel_w, rpm with 8 fraction
// bits) per valid/ready handshake; whl_o returns the four wheel speeds in
// tenths of rpm, normalized to the max_rpm_x10 limit when the largest wheel
// would exceed it. cfg_i writes max_rpm_x10 (index 0) and fine_mode
// (index 1); write it only while no request is in flight.
// Throughput: one request per clock while whl_o.ready is high. Depth: 21
// register stages. The depth is set by the normalizing divider, which
// resolves one quotient bit per stage over 15 stages, after five mixing and
// setup stages and before the output encoding register.
// Reset: pipeline empty, max_rpm_x10 = 5000, fine_mode = 1.
// Stall: a result held on whl_o stays stable while ready is low; the divider
// holds as one block once its last stage is full, the five stages in front of
// it keep filling, and cmd_i.ready drops once those back up, even with empty
// divider stages left. No request is lost or repeated.
// ----------------------------------------------------------------------------
`include "mecanum_wheel_mix_encode_core_defines.svh"

module mecanum_wheel_mix_encode_core (
  input logic        clk_i,
  input logic        rst_ni,
  mwme_cmd_if.sink   cmd_i,
  mwme_cfg_if.sink   cfg_i,
  mwme_whl_if.source whl_o
);
  import mwme_pkg::*;

  rpm_t max_rpm_q;
  logic fine_q;

  logic mix_valid;
  logic mix_ready;
  mix_t mix_data;
  logic scl_valid;
  logic scl_ready;
  div_t scl_data;
  logic div_valid;
  logic div_ready;
  div_t div_data;
  logic [NumWheels-1:0][WheelW-1:0] wheel;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rpm_q <= MaxRpmReset;
      fine_q    <= FineModeReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        RegMaxRpm:   max_rpm_q <= cfg_i.data[RpmW-1:0];
        RegFineMode: fine_q    <= cfg_i.data[0];
      endcase
    end
  end

  mwme_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .vel_y_i     (cmd_i.vel_y),
    .vel_x_i     (cmd_i.vel_x),
    .vel_w_i     (cmd_i.vel_w),
    .out_valid_o (mix_valid),
    .out_ready_i (mix_ready),
    .mix_o       (mix_data)
  );

  mwme_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_rpm_i   (max_rpm_q),
    .fine_i      (fine_q),
    .in_valid_i  (mix_valid),
    .in_ready_o  (mix_ready),
    .mix_i       (mix_data),
    .out_valid_o (scl_valid),
    .out_ready_i (scl_ready),
    .div_o       (scl_data)
  );

  mwme_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (scl_valid),
    .in_ready_o  (scl_ready),
    .div_i       (scl_data),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .div_o       (div_data)
  );

  mwme_encode u_encode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_rpm_i   (max_rpm_q),
    .fine_i      (fine_q),
    .in_valid_i  (div_valid),
    .in_ready_o  (div_ready),
    .div_i       (div_data),
    .out_valid_o (whl_o.valid),
    .out_ready_i (whl_o.ready),
    .wheel_o     (wheel)
  );

  assign whl_o.wheel_a_x10 = wheel[0];
  assign whl_o.wheel_b_x10 = wheel[1];
  assign whl_o.wheel_c_x10 = wheel[2];
  assign whl_o.wheel_d_x10 = wheel[3];

  `MWME_ASSERT_IMP(a_empty_out_takes_cmd, !whl_o.valid, cmd_i.ready, "command stalled with empty output")
  `MWME_ASSERT_IMP(a_wheel_in_range, whl_o.valid, (whl_o.wheel_a_x10 != WheelMinCode) && (whl_o.wheel_b_x10 != WheelMinCode) && (whl_o.wheel_c_x10 != WheelMinCode) && (whl_o.wheel_d_x10 != WheelMinCode), "wheel speed outside limit range")

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// mecanum wheel mixer testbench
// Drives chassis velocity requests through the command channel and checks
// every wheel speed result against a predictor kept in the testbench. A few
// directed requests cover rounding, the normalizing threshold, the zero and
// full-scale speed limits, and coarse truncation. Random requests then run
// under several register settings. The sender works in bursts and the
// receiver stalls, and one long receiver hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mwme_pkg::*;

  localparam int unsigned TimeoutCycles = 300000;
  localparam int unsigned DrainCycles   = 24;

  typedef wheel_t [NumWheels-1:0] wheel_set_t;
  typedef logic signed [VelW-1:0] vel_t;

  logic clk;
  logic rst_n;

  mwme_cmd_if cmd ();
  mwme_cfg_if cfg ();
  mwme_whl_if whl ();

  mecanum_wheel_mix_encode_core dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd),
    .cfg_i (cfg),
    .whl_o (whl)
  );

  rpm_t        speed_limit;
  logic        fine_mode;
  wheel_set_t  wheel_q[$];
  int unsigned mismatches;
  int unsigned burst_left;
  bit          steady_tx;
  int unsigned hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (TimeoutCycles) @(posedge clk);
    $display("testbench NOT OK");
    $finish;
  end

  function automatic wheel_set_t mix_and_encode(input vel_t vy, input vel_t vx, input vel_t vw,
                                                input rpm_t lim, input logic fine);
    longint          y;
    longint          x;
    longint          w;
    longint          sum [NumWheels];
    longint unsigned mag [NumWheels];
    longint unsigned amax;
    longint unsigned m;
    longint unsigned p;
    longint unsigned q;
    longint unsigned r;
    logic            scaled;
    wheel_set_t      res;
    y = vy;
    x = vx;
    w = vw;
    m = lim;
    amax = 0;
    sum[0] = w + y - x;
    sum[1] = w + y + x;
    sum[2] = w - y + x;
    sum[3] = w - y - x;
    for (int i = 0; i < NumWheels; i++) begin
      mag[i] = (sum[i] < 0) ? -sum[i] : sum[i];
      if (mag[i] > amax) amax = mag[i];
    end
    scaled = (10 * amax) > (m << FracBits);
    for (int i = 0; i < NumWheels; i++) begin
      if (fine) begin
        if (scaled) begin
          p = mag[i] * m;
          q = amax;
        end else begin
          p = 10 * mag[i];
          q = 1 << FracBits;
        end
      end else begin
        r = scaled ? (mag[i] * m) / (10 * amax) : (mag[i] >> FracBits);
        p = 10 * r;
        q = 1;
      end
      if (p > m * q) r = m;
      else r = (2 * p + q) / (2 * q);
      res[i] = (sum[i] < 0) ? wheel_t'(0 - r) : wheel_t'(r);
    end
    return res;
  endfunction

  // receiver: randomly chosen stall pattern plus an on-demand hold-off
  initial begin
    int unsigned hold_left;
    int unsigned tick;
    int unsigned mode;
    logic        rdy;
    hold_left = 0;
    tick = 0;
    mode = 0;
    whl.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (mode)
          0: rdy = 1'b1;
          1: rdy = ($urandom_range(0, 3) != 0);
          2: rdy = ($urandom_range(0, 1) != 0);
          default: rdy = ((tick % 5) < 3);
        endcase
      end
      whl.ready <= rdy;
      tick++;
      if (tick % 97 == 0) mode = $urandom_range(0, 3);
    end
  end

  always @(posedge clk) begin
    wheel_set_t want;
    wheel_set_t got;
    if (rst_n && whl.valid && whl.ready) begin
      got[0] = whl.wheel_a_x10;
      got[1] = whl.wheel_b_x10;
      got[2] = whl.wheel_c_x10;
      got[3] = whl.wheel_d_x10;
      if (wheel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected wheel result %0d %0d %0d %0d", got[0], got[1], got[2], got[3]);
      end else begin
        want = wheel_q.pop_front();
        for (int i = 0; i < NumWheels; i++) begin
          if (got[i] !== want[i]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("wheel %0d mismatch: expected %0d, got %0d", i, want[i], got[i]);
          end
        end
      end
    end
  end

  task automatic send_cmd(input vel_t y, input vel_t x, input vel_t w);
    int unsigned gap;
    if (!steady_tx && burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        @(negedge clk);
        cmd.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    @(negedge clk);
    cmd.valid <= 1'b1;
    cmd.vel_y <= y;
    cmd.vel_x <= x;
    cmd.vel_w <= w;
    do @(posedge clk); while (!cmd.ready);
    wheel_q.push_back(mix_and_encode(y, x, w, speed_limit, fine_mode));
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    cmd.valid <= 1'b0;
    while (wheel_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    wait_quiet();
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    if (idx == RegMaxRpm) speed_limit = data[RpmW-1:0];
    else fine_mode = data[0];
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  function automatic vel_t rand_vel(input rpm_t lim);
    int b;
    int v;
    b = (int'(lim) * 256) / 30 + 1;
    case ($urandom_range(0, 9))
      0, 1: v = $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0: v = -8388608;
          1: v = 8388607;
          2: v = 0;
          default: v = -1;
        endcase
      end
      3, 4: v = int'($urandom_range(0, 2 * b)) - b;
      5, 6: v = int'($urandom_range(0, 1200)) - 600;
      7: v = ($urandom_range(0, 1) ? b : -b) + int'($urandom_range(0, 8)) - 4;
      default: v = int'($urandom_range(0, 6 * b)) - 3 * b;
    endcase
    return vel_t'(v);
  endfunction

  task automatic test_default_encoding();
    send_cmd(0, 0, 0);
    send_cmd(0, 0, 64);
    send_cmd(0, 0, -64);
    send_cmd(0, 0, 128000);
    send_cmd(0, 0, 128001);
    send_cmd(8388607, 8388607, 8388607);
    send_cmd(-8388608, -8388608, -8388608);
    send_cmd(8388607, -8388608, 0);
    send_cmd(1000, -700, 33);
  endtask

  task automatic test_coarse_truncation();
    write_reg(RegFineMode, 16'hFFFE);
    send_cmd(0, 0, 968);
    send_cmd(0, 0, -968);
    send_cmd(255, 0, 0);
    send_cmd(5000, 0, 128001);
    send_cmd(-8388608, 8388607, -8388608);
  endtask

  task automatic test_limit_extremes();
    write_reg(RegMaxRpm, 16'h0000);
    write_reg(RegFineMode, 16'h0001);
    send_cmd(0, 0, 1);
    send_cmd(0, 0, 0);
    send_cmd(-8388608, 8388607, 8388607);
    write_reg(RegMaxRpm, 16'hFFFF);
    send_cmd(0, 0, 838835);
    send_cmd(0, 0, 838836);
    send_cmd(8388607, 8388607, -8388608);
    write_reg(RegFineMode, 16'h0000);
    send_cmd(8388607, 8388607, 8388607);
    send_cmd(0, -300000, 1);
    write_reg(RegMaxRpm, 16'h0001);
    send_cmd(0, 0, 25);
    send_cmd(0, 0, -26);
  endtask

  task automatic test_random_settings();
    rpm_t limits [8];
    logic modes [8];
    limits = '{15'd5000, 15'd5000, 15'd0, 15'd32767, 15'd32767, 15'd1,
               rpm_t'($urandom), rpm_t'($urandom_range(1, 2000))};
    modes = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    for (int k = 0; k < 8; k++) begin
      write_reg(RegMaxRpm, {1'b0, limits[k]});
      write_reg(RegFineMode, {15'($urandom), modes[k]});
      repeat (225) send_cmd(rand_vel(speed_limit), rand_vel(speed_limit), rand_vel(speed_limit));
    end
  endtask

  task automatic test_backpressure();
    write_reg(RegMaxRpm, 16'd5000);
    write_reg(RegFineMode, 16'd1);
    @(posedge clk);
    hold_req = 300;
    steady_tx = 1'b1;
    repeat (64) send_cmd(rand_vel(speed_limit), rand_vel(speed_limit), rand_vel(speed_limit));
    steady_tx = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cmd.valid = 1'b0;
    cmd.vel_y = '0;
    cmd.vel_x = '0;
    cmd.vel_w = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data  = '0;
    speed_limit = MaxRpmReset;
    fine_mode = FineModeReset;
    mismatches = 0;
    burst_left = 0;
    steady_tx = 1'b0;
    hold_req = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_default_encoding();
    test_coarse_truncation();
    test_limit_extremes();
    test_backpressure();
    test_random_settings();

    wait_quiet();
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/mwme_pkg.sv
rtl/mwme_if.sv
rtl/mwme_mix.sv
rtl/mwme_scale.sv
rtl/mwme_divider.sv
rtl/mwme_encode.sv
rtl/mecanum_wheel_mix_encode_core.sv
verif/testbench.sv
